[hw/rtl/rsia_pkg.sv]
// Shared constants, types and helpers for the rotating sequence-id allocator.
// No dependencies; imported by the row evaluator and the top level.
`timescale 1ns / 1ps

package rsia_pkg;

  localparam int SEQ_MIN     = 1;
  localparam int SEQ_MAX     = 255;
  localparam int NUM_CLIENTS = 8;

  localparam int CMD_W    = 2;
  localparam int CLIENT_W = 3;
  localparam int SEQ_W    = 8;
  localparam int STATUS_W = 2;

  // One memory row holds SLOTS in-use bits followed by SLOTS owner fields.
  localparam int SLOT_W = 4;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int ROW_AW = SEQ_W - SLOT_W;
  localparam int ROWS   = 1 << ROW_AW;
  localparam int ROW_W  = SLOTS * (1 + CLIENT_W);
  localparam int STEP_W = ROW_AW + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC       = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_ALL = 2'd2,
    CMD_RESET       = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_OWNER = 2'd3
  } status_t;

  // Control into the row evaluator
  typedef struct packed {
    logic                wrapped;   // second pass of the circular search
    logic [ROW_AW-1:0]   row_idx;
    logic [SEQ_W-1:0]    start;
    logic [CLIENT_W-1:0] client;
    logic [SLOT_W-1:0]   rel_slot;
  } row_ctl_t;

  // Status back from the row evaluator
  typedef struct packed {
    logic              alloc_hit;
    logic [SLOT_W-1:0] alloc_slot;
    logic              rel_owned;
  } row_stat_t;

  function automatic logic in_range(logic [SEQ_W-1:0] s);
    return (int'(s) >= SEQ_MIN) && (int'(s) <= SEQ_MAX);
  endfunction

  function automatic logic client_ok(logic [CLIENT_W-1:0] c);
    return int'(c) < NUM_CLIENTS;
  endfunction

endpackage

[hw/rtl/rsia_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rsia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/rsia_row_ops.sv]
// Row evaluator: free-slot search window, first-free encode, ownership check
// and the modified rows for allocate, release and release-all. Uses rsia_pkg.
`timescale 1ns / 1ps

module rsia_row_ops (
  input  logic [rsia_pkg::ROW_W-1:0] row_in,
  input  rsia_pkg::row_ctl_t         ctl,
  output rsia_pkg::row_stat_t        stat,
  output logic [rsia_pkg::ROW_W-1:0] alloc_row,
  output logic [rsia_pkg::ROW_W-1:0] rel_row,
  output logic [rsia_pkg::ROW_W-1:0] relall_row
);
  import rsia_pkg::*;

  logic [SLOTS-1:0]  used;
  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  win;
  logic [SLOTS-1:0]  free;
  logic [SLOTS-1:0]  first;
  logic [SLOTS-1:0]  rel_used;
  logic [SLOT_W-1:0] slot;

  always_comb begin : win_blk
    logic [SEQ_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pos      = {ctl.row_idx, SLOT_W'(i)};
      used[i]  = row_in[i];
      match[i] = (row_in[SLOTS + i*CLIENT_W +: CLIENT_W] == ctl.client);
      // first pass covers start..max, the wrapped pass min..start-1
      if (ctl.wrapped) begin
        win[i] = in_range(pos) && (pos < ctl.start);
      end else begin
        win[i] = in_range(pos) && (pos >= ctl.start);
      end
    end
  end

  assign free  = ~used & win;
  assign first = free & (~free + SLOTS'(1));

  always_comb begin
    slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    alloc_row = row_in;
    alloc_row[SLOTS-1:0] = used | first;
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i]) begin
        alloc_row[SLOTS + i*CLIENT_W +: CLIENT_W] = ctl.client;
      end
    end
  end

  always_comb begin
    rel_used = used;
    rel_used[ctl.rel_slot] = 1'b0;
  end

  assign rel_row    = {row_in[ROW_W-1:SLOTS], rel_used};
  assign relall_row = {row_in[ROW_W-1:SLOTS], used & ~match};

  assign stat = '{
    alloc_hit:  |free,
    alloc_slot: slot,
    rel_owned:  used[ctl.rel_slot] && match[ctl.rel_slot]
  };

endmodule

[hw/rtl/rotating_sequence_id_allocator_unit.sv]
// Top level of the rotating sequence-id allocator: command sequencer around
// the row memory. Uses rsia_pkg, rsia_ram and rsia_row_ops.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its single result
// shows on out_status/out_seq_out for one cycle with out_strobe high, and the
// receiver must take it then. All state lives in one 16-row x 64-bit memory
// (16 in-use bits and 16 owner fields per row) with a single read port, so
// scans move at one row per cycle. Commands rejected up front (bad range,
// bad client) are answered from the idle state; release reads one row and
// rewrites it if owned; allocate takes longer the further the circular scan
// runs from the last granted number; release-all walks every row; reset runs a clearing pass.
// After rst_n the same clearing pass runs with busy high.
module rotating_sequence_id_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rsia_pkg::CMD_W-1:0]    in_command,
  input  logic [rsia_pkg::CLIENT_W-1:0] in_client,
  input  logic [rsia_pkg::SEQ_W-1:0]    in_seq_in,
  output logic                          out_strobe,
  output logic [rsia_pkg::STATUS_W-1:0] out_status,
  output logic [rsia_pkg::SEQ_W-1:0]    out_seq_out
);
  import rsia_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ALLOC  = 5'b00100,
    S_REL    = 5'b01000,
    S_RELALL = 5'b10000
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROWS);
  localparam logic [STEP_W-1:0] LAST_ROW  = STEP_W'(ROWS - 1);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   rk_r, rk_nxt;       // read step
  logic [STEP_W-1:0]   ek_r, ek_nxt;       // step of the row now on rdata
  logic                ev_r, ev_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  logic [SEQ_W-1:0]    last_r, last_nxt;
  logic [CLIENT_W-1:0] client_r, client_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [SEQ_W-1:0]    scan_start_r, scan_start_nxt;
  logic                strobe_r, strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SEQ_W-1:0]    seqo_r, seqo_nxt;

  logic                mem_we, mem_re;
  logic [ROW_AW-1:0]   mem_waddr, mem_raddr;
  logic [ROW_W-1:0]    mem_wdata, mem_rdata;

  logic [STEP_W-1:0]   rsum, esum;
  logic [SEQ_W:0]      after_last;
  row_ctl_t            rctl;
  row_stat_t           rstat;
  logic [ROW_W-1:0]    alloc_row, rel_row, relall_row;

  rsia_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rsia_row_ops u_row (
    .row_in     (mem_rdata),
    .ctl        (rctl),
    .stat       (rstat),
    .alloc_row  (alloc_row),
    .rel_row    (rel_row),
    .relall_row (relall_row)
  );

  // circular row walk: bit ROW_AW of the sum flags the wrapped pass
  assign rsum       = {1'b0, scan_start_r[SEQ_W-1 -: ROW_AW]} + rk_r;
  assign esum       = {1'b0, scan_start_r[SEQ_W-1 -: ROW_AW]} + ek_r;
  assign after_last = {1'b0, last_r} + (SEQ_W + 1)'(1);

  assign rctl = '{
    wrapped:  esum[STEP_W-1],
    row_idx:  esum[ROW_AW-1:0],
    start:    scan_start_r,
    client:   client_r,
    rel_slot: seq_r[SLOT_W-1:0]
  };

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    rk_nxt         = rk_r;
    ek_nxt         = rk_r;
    ev_nxt         = 1'b0;
    clr_resp_nxt   = clr_resp_r;
    last_nxt       = last_r;
    client_nxt     = client_r;
    seq_nxt        = seq_r;
    scan_start_nxt = scan_start_r;
    strobe_nxt     = 1'b0;
    status_nxt     = status_r;
    seqo_nxt       = seqo_r;
    mem_we         = 1'b0;
    mem_waddr      = ek_r[ROW_AW-1:0];
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = rk_r[ROW_AW-1:0];

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rk_r[ROW_AW-1:0];
        mem_wdata = '0;
        rk_nxt    = rk_r + STEP_W'(1);
        if (rk_r == LAST_ROW) begin
          state_nxt = S_IDLE;
          if (clr_resp_r) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_OK;
            seqo_nxt   = '0;
          end
        end
      end

      S_IDLE: begin
        if (start) begin
          client_nxt = in_client;
          seq_nxt    = in_seq_in;
          rk_nxt     = '0;
          seqo_nxt   = '0;
          case (cmd_t'(in_command))
            CMD_ALLOC: begin
              if (client_ok(in_client)) begin
                state_nxt = S_ALLOC;
                if ((int'(after_last) >= SEQ_MIN) && (int'(after_last) <= SEQ_MAX)) begin
                  scan_start_nxt = after_last[SEQ_W-1:0];
                end else begin
                  scan_start_nxt = SEQ_W'(SEQ_MIN);
                end
              end else begin
                strobe_nxt = 1'b1;
                status_nxt = ST_NONE;
              end
            end
            CMD_RELEASE: begin
              if (!in_range(in_seq_in)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_RANGE;
              end else if (!client_ok(in_client)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_NOT_OWNER;
              end else begin
                state_nxt = S_REL;
              end
            end
            CMD_RELEASE_ALL: begin
              if (client_ok(in_client)) begin
                state_nxt = S_RELALL;
              end else begin
                strobe_nxt = 1'b1;
                status_nxt = ST_OK;
              end
            end
            CMD_RESET: begin
              state_nxt    = S_CLEAR;
              clr_resp_nxt = 1'b1;
              last_nxt     = SEQ_W'(SEQ_MAX);
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (rk_r <= LAST_STEP) begin
          mem_re    = 1'b1;
          mem_raddr = rsum[ROW_AW-1:0];
          ev_nxt    = 1'b1;
          rk_nxt    = rk_r + STEP_W'(1);
        end
        if (ev_r) begin
          if (rstat.alloc_hit) begin
            mem_we     = 1'b1;
            mem_waddr  = esum[ROW_AW-1:0];
            mem_wdata  = alloc_row;
            last_nxt   = {esum[ROW_AW-1:0], rstat.alloc_slot};
            seqo_nxt   = {esum[ROW_AW-1:0], rstat.alloc_slot};
            status_nxt = ST_OK;
            strobe_nxt = 1'b1;
            ev_nxt     = 1'b0;
            state_nxt  = S_IDLE;
          end else if (ek_r == LAST_STEP) begin
            seqo_nxt   = '0;
            status_nxt = ST_NONE;
            strobe_nxt = 1'b1;
            ev_nxt     = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_REL: begin
        if (!ev_r) begin
          mem_re    = 1'b1;
          mem_raddr = seq_r[SEQ_W-1 -: ROW_AW];
          ev_nxt    = 1'b1;
        end else begin
          if (rstat.rel_owned) begin
            mem_we     = 1'b1;
            mem_waddr  = seq_r[SEQ_W-1 -: ROW_AW];
            mem_wdata  = rel_row;
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_NOT_OWNER;
          end
          seqo_nxt   = '0;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_RELALL: begin
        if (rk_r <= LAST_ROW) begin
          mem_re    = 1'b1;
          mem_raddr = rk_r[ROW_AW-1:0];
          ev_nxt    = 1'b1;
          rk_nxt    = rk_r + STEP_W'(1);
        end
        // write back row k while row k+1 is being read
        if (ev_r) begin
          mem_we    = 1'b1;
          mem_waddr = ek_r[ROW_AW-1:0];
          mem_wdata = relall_row;
          if (ek_r == LAST_ROW) begin
            seqo_nxt   = '0;
            status_nxt = ST_OK;
            strobe_nxt = 1'b1;
            ev_nxt     = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        rk_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      rk_r       <= '0;
      ev_r       <= 1'b0;
      clr_resp_r <= 1'b0;
      last_r     <= SEQ_W'(SEQ_MAX);
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rk_r       <= rk_nxt;
      ev_r       <= ev_nxt;
      clr_resp_r <= clr_resp_nxt;
      last_r     <= last_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ek_r         <= ek_nxt;
    client_r     <= client_nxt;
    seq_r        <= seq_nxt;
    scan_start_r <= scan_start_nxt;
    status_r     <= status_nxt;
    seqo_r       <= seqo_nxt;
  end

  assign out_strobe  = strobe_r;
  assign out_status  = status_r;
  assign out_seq_out = seqo_r;

  // read-modify-write never touches the row being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("row memory read and write hit the same row");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_r && state_r == S_ALLOC) |-> (ek_r <= LAST_STEP))
    else $error("allocate scan ran past its last row");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_seq_out == '0))
    else $error("nonzero sequence number on a failed request");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_OK && out_seq_out != '0) |-> in_range(out_seq_out))
    else $error("granted sequence number out of range");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request in flight");

endmodule
